// File: src/beep_pattern_actuator_sequencer_top_macros.svh
`ifndef BEEP_PATTERN_ACTUATOR_SEQUENCER_TOP_MACROS_SVH
`define BEEP_PATTERN_ACTUATOR_SEQUENCER_TOP_MACROS_SVH

// Concurrent check on the block clock, quiet while reset is asserted.
`define BPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: the consequent must hold in the cycle after the trigger.
`define BPS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bps_pkg.sv
`default_nettype none

package bps_pkg;

  // Fixed widths of the timestamp and the detector hit counter.
  localparam int TimeBits = 32;
  localparam int HitBits  = 16;
  localparam int CfgBits  = 16;
  localparam int CfgIdxBits = 3;

  // Sequencer phases.
  typedef enum logic [1:0] {
    PH_LISTEN  = 2'd0,
    PH_OPEN    = 2'd1,
    PH_RETRACT = 2'd2
  } phase_e;

  // Command codes carried by each tick.
  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_OPEN    = 2'd1;
  localparam logic [1:0] MODE_RETRACT = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] REG_DETECT_THRESHOLD = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_WINDOW_LOW       = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_WINDOW_HIGH      = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_IDLE_DECAY       = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_STRIKE_LIMIT     = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_OPEN_TIME        = 3'd5;
  localparam logic [CfgIdxBits-1:0] REG_RETRACT_TIME     = 3'd6;

  // Register reset values.
  localparam logic [15:0] RST_DETECT_THRESHOLD = 16'd500;
  localparam logic [15:0] RST_WINDOW_LOW       = 16'd5000;
  localparam logic [15:0] RST_WINDOW_HIGH      = 16'd7000;
  localparam logic [15:0] RST_IDLE_DECAY       = 16'd10000;
  localparam logic [7:0]  RST_STRIKE_LIMIT     = 8'd3;
  localparam logic [15:0] RST_OPEN_TIME        = 16'd5000;
  localparam logic [15:0] RST_RETRACT_TIME     = 16'd10000;

  // One tick word.
  typedef struct packed {
    logic [TimeBits-1:0] now_ms;
    logic                detector_level;
    logic [1:0]          mode;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic [1:0] phase;
    logic       drive_enable;
    logic       drive_a;
    logic       drive_b;
    logic       detection_seen;
    logic       strike_seen;
    logic       phase_changed;
  } out_item_t;

endpackage

`default_nettype wire

// File: src/beep_pattern_actuator_sequencer_top.sv
// An accepted tick word passes the input register, then the result register, before
// its result word appears.
// One tick word per cycle while the result side takes its words; the state update is a
// single pass of compares and 32-bit subtracts between the input register and the result register.
// Reset (asynchronous, active low) empties both registers, returns to listening with
// all counters and times at zero, and loads the register defaults.
`default_nettype none

`include "beep_pattern_actuator_sequencer_top_macros.svh"

module beep_pattern_actuator_sequencer_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  bps_pkg::in_item_t         in_data_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output bps_pkg::out_item_t              out_data_o,
  input  wire                             cfg_we_i,
  input  wire  [bps_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire  [bps_pkg::CfgBits-1:0]     cfg_wdata_i
);
  import bps_pkg::*;

  localparam logic [HitBits-1:0] HitMax    = '1;
  localparam logic [7:0]         StrikeMax = '1;

  // Configuration registers.
  logic [15:0] thresh_q, win_lo_q, win_hi_q, idle_q, open_t_q, retract_t_q;
  logic [7:0]  limit_q;

  // Pipeline registers.
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      advance;

  // Sequencer state.
  phase_e              phase_q, phase_d, phase_cmd;
  logic [HitBits-1:0]  hit_q, hit_d, hit_inc;
  logic [7:0]          strike_q, strike_d, strike_det, strike_dec;
  logic [TimeBits-1:0] last_q, last_d, pst_q, pst_d, pst_cmd;
  logic [TimeBits-1:0] now, elapsed, gap, idle_gap;
  logic                present, detected, strike;
  out_item_t           result;

  // Terms watched by the checks.
  logic legs_both, lone_strike, open_by_strikes, opened_clean, in_held;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= RST_DETECT_THRESHOLD;
      win_lo_q    <= RST_WINDOW_LOW;
      win_hi_q    <= RST_WINDOW_HIGH;
      idle_q      <= RST_IDLE_DECAY;
      limit_q     <= RST_STRIKE_LIMIT;
      open_t_q    <= RST_OPEN_TIME;
      retract_t_q <= RST_RETRACT_TIME;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DETECT_THRESHOLD: thresh_q    <= cfg_wdata_i;
        REG_WINDOW_LOW:       win_lo_q    <= cfg_wdata_i;
        REG_WINDOW_HIGH:      win_hi_q    <= cfg_wdata_i;
        REG_IDLE_DECAY:       idle_q      <= cfg_wdata_i;
        REG_STRIKE_LIMIT:     limit_q     <= cfg_wdata_i[7:0];
        REG_OPEN_TIME:        open_t_q    <= cfg_wdata_i;
        REG_RETRACT_TIME:     retract_t_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the held word moves on whenever the result register is free or drains.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Command decode: a command forces its phase and restarts the phase timer.
  assign now     = in_q.now_ms;
  assign present = !in_q.detector_level;

  always_comb begin
    phase_cmd = phase_q;
    pst_cmd   = pst_q;
    if (in_q.mode == MODE_OPEN) begin
      phase_cmd = PH_OPEN;
      pst_cmd   = now;
    end else if (in_q.mode == MODE_RETRACT) begin
      phase_cmd = PH_RETRACT;
      pst_cmd   = now;
    end
  end

  assign elapsed = now - pst_cmd;
  assign gap     = now - last_q;

  // Listening: hit counter, detection, strike window.
  assign hit_inc  = (hit_q < HitMax) ? hit_q + 1'b1 : hit_q;
  assign detected = present && (hit_inc > thresh_q);
  assign strike   = detected && (gap > TimeBits'(win_lo_q)) && (gap < TimeBits'(win_hi_q));

  always_comb begin
    strike_det = strike_q;
    if (strike && strike_q < StrikeMax) begin
      strike_det = strike_q + 1'b1;
    end
  end

  // Idle gap is measured against the detection time after this tick.
  assign idle_gap   = detected ? '0 : gap;
  assign strike_dec = (idle_gap > TimeBits'(idle_q) && strike_det != '0)
                    ? strike_det - 1'b1 : strike_det;

  // Phase step.
  always_comb begin
    phase_d  = phase_cmd;
    pst_d    = pst_cmd;
    hit_d    = hit_q;
    strike_d = strike_q;
    last_d   = last_q;
    unique case (phase_cmd)
      PH_OPEN: begin
        if (elapsed > TimeBits'(open_t_q)) begin
          phase_d = PH_RETRACT;
          pst_d   = now;
        end
      end
      PH_RETRACT: begin
        if (elapsed > TimeBits'(retract_t_q)) begin
          phase_d = PH_LISTEN;
          pst_d   = now;
        end
      end
      default: begin
        phase_d = PH_LISTEN;
        if (present) begin
          hit_d = detected ? '0 : hit_inc;
        end else if (hit_q != '0) begin
          hit_d = hit_q - 1'b1;
        end
        if (detected) begin
          last_d = now;
        end
        strike_d = strike_dec;
        if (strike_dec > limit_q) begin
          phase_d  = PH_OPEN;
          strike_d = '0;
          pst_d    = now;
        end
      end
    endcase
  end

  // Result word.
  always_comb begin
    result.phase          = phase_d;
    result.drive_enable   = (phase_d != PH_LISTEN);
    result.drive_a        = (phase_d == PH_RETRACT);
    result.drive_b        = (phase_d == PH_OPEN);
    result.detection_seen = (phase_cmd == PH_LISTEN) && detected;
    result.strike_seen    = (phase_cmd == PH_LISTEN) && strike;
    result.phase_changed  = (phase_d != phase_q);
  end

  // Input register, state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_LISTEN;
      hit_q       <= '0;
      strike_q    <= '0;
      last_q      <= '0;
      pst_q       <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        hit_q       <= hit_d;
        strike_q    <= strike_d;
        last_q      <= last_d;
        pst_q       <= pst_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  // Checks.
  assign legs_both       = out_valid_q && out_q.drive_a && out_q.drive_b;
  assign lone_strike     = out_valid_q && out_q.strike_seen && !out_q.detection_seen;
  assign open_by_strikes = advance && (phase_cmd == PH_LISTEN) && (phase_d == PH_OPEN);
  assign opened_clean    = (strike_q == '0) && (phase_q == PH_OPEN);
  assign in_held         = in_valid_q && !advance;

  `BPS_ASSERT(a_legs_exclusive, !legs_both, "both bridge legs driven")
  `BPS_ASSERT(a_strike_needs_det, !lone_strike, "strike without detection")
  `BPS_ASSERT_NEXT(a_open_clears, open_by_strikes, opened_clean, "strikes kept on opening")
  `BPS_ASSERT_NEXT(a_held_word_stays, in_held, in_valid_q && $stable(in_q), "held word lost")

endmodule

`default_nettype wire

// File: tb/sv/beep_pattern_actuator_sequencer_top_tb.sv
module beep_pattern_actuator_sequencer_top_tb;
  import bps_pkg::*;

  // The spare command code, which the block treats as no command.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [HitBits-1:0] HIT_MAX = {HitBits{1'b1}};
  localparam logic [7:0] STRIKE_MAX = 8'hFF;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned RUN_LIMIT = 1000000;
  localparam int unsigned REPORT_CAP = 100;

  // Tracks the sequencer state and holds the result words still due.
  class sequencer_tracker;
    logic [15:0] cfg_threshold, cfg_win_low, cfg_win_high, cfg_decay;
    logic [15:0] cfg_open_ms, cfg_retract_ms;
    logic [7:0] cfg_strike_limit;
    phase_e phase_now;
    logic [HitBits-1:0] hits;
    logic [7:0] strikes;
    logic [TimeBits-1:0] last_hit_ms, phase_start_ms;
    out_item_t tick_outcomes_q[$];
    int unsigned fail_cnt;

    function new();
      cfg_threshold = RST_DETECT_THRESHOLD;
      cfg_win_low = RST_WINDOW_LOW;
      cfg_win_high = RST_WINDOW_HIGH;
      cfg_decay = RST_IDLE_DECAY;
      cfg_strike_limit = RST_STRIKE_LIMIT;
      cfg_open_ms = RST_OPEN_TIME;
      cfg_retract_ms = RST_RETRACT_TIME;
      phase_now = PH_LISTEN;
      hits = '0;
      strikes = '0;
      last_hit_ms = '0;
      phase_start_ms = '0;
      fail_cnt = 0;
    endfunction

    function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] data);
      case (idx)
        REG_DETECT_THRESHOLD: cfg_threshold = data;
        REG_WINDOW_LOW: cfg_win_low = data;
        REG_WINDOW_HIGH: cfg_win_high = data;
        REG_IDLE_DECAY: cfg_decay = data;
        REG_STRIKE_LIMIT: cfg_strike_limit = data[7:0];
        REG_OPEN_TIME: cfg_open_ms = data;
        REG_RETRACT_TIME: cfg_retract_ms = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return tick_outcomes_q.size();
    endfunction

    // Advance the state by one accepted tick word and queue its result word.
    function void note_tick(in_item_t tick);
      phase_e prev_phase;
      logic [TimeBits-1:0] elapsed;
      logic detected, strike;
      out_item_t outcome;
      prev_phase = phase_now;
      detected = 1'b0;
      strike = 1'b0;

      // A command restarts the phase timer even when the phase does not change.
      if (tick.mode == MODE_OPEN) begin
        phase_now = PH_OPEN;
        phase_start_ms = tick.now_ms;
      end else if (tick.mode == MODE_RETRACT) begin
        phase_now = PH_RETRACT;
        phase_start_ms = tick.now_ms;
      end

      elapsed = tick.now_ms - phase_start_ms;
      case (phase_now)
        PH_OPEN: begin
          if (elapsed > cfg_open_ms) begin
            phase_now = PH_RETRACT;
            phase_start_ms = tick.now_ms;
          end
        end
        PH_RETRACT: begin
          if (elapsed > cfg_retract_ms) begin
            phase_now = PH_LISTEN;
            phase_start_ms = tick.now_ms;
          end
        end
        default: begin
          phase_now = PH_LISTEN;
          // Up/down hit counter, saturating at both ends.
          if (!tick.detector_level) begin
            if (hits != HIT_MAX) hits = hits + 1'b1;
            if (hits > cfg_threshold) begin
              elapsed = tick.now_ms - last_hit_ms;
              detected = 1'b1;
              hits = '0;
              if (elapsed > cfg_win_low && elapsed < cfg_win_high) begin
                strike = 1'b1;
                if (strikes != STRIKE_MAX) strikes = strikes + 1'b1;
              end
              last_hit_ms = tick.now_ms;
            end
          end else if (hits != '0) begin
            hits = hits - 1'b1;
          end
          // Strikes fade while detections stay away.
          elapsed = tick.now_ms - last_hit_ms;
          if (elapsed > cfg_decay && strikes != '0) strikes = strikes - 1'b1;
          if (strikes > cfg_strike_limit) begin
            phase_now = PH_OPEN;
            strikes = '0;
            phase_start_ms = tick.now_ms;
          end
        end
      endcase

      outcome.phase = phase_now;
      outcome.drive_enable = (phase_now != PH_LISTEN);
      outcome.drive_a = (phase_now == PH_RETRACT);
      outcome.drive_b = (phase_now == PH_OPEN);
      outcome.detection_seen = detected;
      outcome.strike_seen = strike;
      outcome.phase_changed = (phase_now != prev_phase);
      tick_outcomes_q.push_back(outcome);
    endfunction

    function void flag(string field, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        fail_cnt++;
        // Keep the log short when the block is badly broken.
        if (fail_cnt <= REPORT_CAP)
          $error("%s mismatch: expected %0d, got %0d", field, want, got);
      end
    endfunction

    // Compare one accepted result word against the oldest prediction.
    function void check_outcome(out_item_t got);
      out_item_t want;
      if (tick_outcomes_q.size() == 0) begin
        fail_cnt++;
        $error("result word arrived with no tick word outstanding");
        return;
      end
      want = tick_outcomes_q.pop_front();
      flag("phase", want.phase, got.phase);
      flag("drive_enable", want.drive_enable, got.drive_enable);
      flag("drive_a", want.drive_a, got.drive_a);
      flag("drive_b", want.drive_b, got.drive_b);
      flag("detection_seen", want.detection_seen, got.detection_seen);
      flag("strike_seen", want.strike_seen, got.strike_seen);
      flag("phase_changed", want.phase_changed, got.phase_changed);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  logic [CfgBits-1:0] cfg_wdata = '0;

  sequencer_tracker sb = new();
  int unsigned in_gap_max = 0;
  int unsigned out_gap_max = 0;
  bit hold_request = 1'b0;
  logic [TimeBits-1:0] stamp_ms = '0;
  int unsigned cycle_count = 0;

  beep_pattern_actuator_sequencer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      sb.check_outcome(out_data);
    end
  end

  // Offer one tick word after a random gap; valid stays high into the next word.
  task automatic send_tick(input in_item_t tick);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= tick;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_tick(tick);
  endtask

  task automatic send_at(input logic [TimeBits-1:0] stamp, input logic level,
                         input logic [1:0] mode);
    in_item_t tick;
    tick.now_ms = stamp;
    tick.detector_level = level;
    tick.mode = mode;
    stamp_ms = stamp;
    send_tick(tick);
  endtask

  // Stop offering and let every outstanding result word come back.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgBits-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [15:0] threshold, input logic [15:0] win_low,
                                input logic [15:0] win_high, input logic [15:0] decay,
                                input logic [7:0] limit, input logic [15:0] open_ms,
                                input logic [15:0] retract_ms);
    write_reg(REG_DETECT_THRESHOLD, threshold);
    write_reg(REG_WINDOW_LOW, win_low);
    write_reg(REG_WINDOW_HIGH, win_high);
    write_reg(REG_IDLE_DECAY, decay);
    write_reg(REG_STRIKE_LIMIT, {8'd0, limit});
    write_reg(REG_OPEN_TIME, open_ms);
    write_reg(REG_RETRACT_TIME, retract_ms);
    cfg_we <= 1'b0;
  endtask

  // Small windows and timers so that detections, strikes and phase cycles happen often.
  task automatic apply_lively_settings();
    logic [15:0] win_low;
    win_low = 16'($urandom_range(0, 40));
    apply_settings(16'($urandom_range(0, 3)), win_low,
                   win_low + 16'($urandom_range(20, 200)), 16'($urandom_range(40, 400)),
                   8'($urandom_range(0, 5)), 16'($urandom_range(0, 300)),
                   16'($urandom_range(0, 300)));
  endtask

  // Random ticks: mostly short time steps and detector bursts, some wild jumps.
  task automatic run_random_ticks(input int unsigned count, input int unsigned step_max,
                                  input int unsigned present_pct);
    in_item_t tick;
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) stamp_ms = $urandom();
      else stamp_ms = stamp_ms + $urandom_range(0, step_max);
      tick.now_ms = stamp_ms;
      tick.detector_level = ($urandom_range(0, 99) >= present_pct);
      pick = $urandom_range(0, 99);
      if (pick < 2) tick.mode = MODE_OPEN;
      else if (pick < 4) tick.mode = MODE_RETRACT;
      else if (pick < 5) tick.mode = MODE_UNUSED;
      else tick.mode = MODE_NONE;
      send_tick(tick);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Commands, timer boundaries and timestamp wrap at the reset settings.
    in_gap_max = 3;
    out_gap_max = 3;
    send_at(32'd0, 1'b1, MODE_NONE);
    send_at(32'hFFFF_FFFF, 1'b0, MODE_NONE);
    send_at(32'd5, 1'b1, MODE_OPEN);
    send_at(32'd5005, 1'b1, MODE_NONE);
    send_at(32'd5006, 1'b1, MODE_NONE);
    send_at(32'd5006, 1'b0, MODE_OPEN);
    send_at(32'd5006, 1'b1, MODE_RETRACT);
    send_at(32'd5006, 1'b1, MODE_RETRACT);
    send_at(32'd15006, 1'b1, MODE_NONE);
    send_at(32'd15007, 1'b1, MODE_UNUSED);
    send_at(32'hFFFF_FFF0, 1'b1, MODE_OPEN);
    send_at(32'h0000_1390, 1'b1, MODE_NONE);
    send_at(32'h0000_1390, 1'b1, MODE_NONE);
    wait_quiet();

    // Zero durations end a phase on the first tick with time elapsed.
    apply_settings(16'd1, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
    send_at(32'd100, 1'b1, MODE_OPEN);
    send_at(32'd100, 1'b1, MODE_NONE);
    send_at(32'd101, 1'b1, MODE_NONE);
    send_at(32'd101, 1'b1, MODE_NONE);
    send_at(32'd102, 1'b1, MODE_NONE);
    send_at(32'd103, 1'b0, MODE_NONE);
    send_at(32'd104, 1'b0, MODE_NONE);
    send_at(32'd105, 1'b1, MODE_NONE);
    wait_quiet();

    // Strike counter saturation with a limit that can never be passed,
    // then a lower limit opens on the next tick.
    in_gap_max = 0;
    out_gap_max = 0;
    apply_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'hFF, 16'd100, 16'd100);
    for (int unsigned k = 0; k < 300; k++) send_at(stamp_ms + 32'd10, 1'b0, MODE_NONE);
    wait_quiet();
    write_reg(REG_STRIKE_LIMIT, 16'd254);
    cfg_we <= 1'b0;
    send_at(stamp_ms + 32'd10, 1'b1, MODE_NONE);
    wait_quiet();

    // Hit counter: a threshold out of reach lets the count build up,
    // then a lower threshold is passed on the next present tick.
    apply_settings(16'hFFFF, RST_WINDOW_LOW, RST_WINDOW_HIGH, RST_IDLE_DECAY,
                   RST_STRIKE_LIMIT, RST_OPEN_TIME, RST_RETRACT_TIME);
    send_at(stamp_ms + 32'd6000, 1'b1, MODE_NONE);
    send_at(stamp_ms + 32'd11000, 1'b1, MODE_NONE);
    for (int unsigned k = 0; k < 40; k++) send_at(stamp_ms + 32'd1, 1'b0, MODE_NONE);
    wait_quiet();
    write_reg(REG_DETECT_THRESHOLD, 16'd30);
    cfg_we <= 1'b0;
    send_at(stamp_ms + 32'd1, 1'b0, MODE_NONE);
    wait_quiet();

    // Random phases, each under its own settings and idling pattern.
    for (int unsigned p = 0; p < 11; p++) begin
      in_gap_max = (p % 3 == 0) ? 0 : 14;
      out_gap_max = (p % 4 == 1) ? 0 : 14;
      if (p == 0) apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
      else if (p == 1)
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      else if (p == 2) apply_settings(16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 8'd254, 16'd50, 16'd50);
      else apply_lively_settings();
      if (p == 5) begin
        // Long receiver hold-off while ticks keep coming.
        in_gap_max = 0;
        hold_request = 1'b1;
      end
      if (p == 7) stamp_ms = 32'hFFFF_FC00;
      run_random_ticks(120, 30, 60 + $urandom_range(0, 25));
      wait_quiet();
    end

    if (sb.fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
